### src/rrb_pkg.sv
`timescale 1ns / 1ps
package rrb_pkg;

	localparam logic [2:0] CMD_FILL     = 3'd0;
	localparam logic [2:0] CMD_BEGIN_RD = 3'd1;
	localparam logic [2:0] CMD_BEGIN_WR = 3'd2;
	localparam logic [2:0] CMD_COPY     = 3'd3;
	localparam logic [2:0] CMD_STREAM   = 3'd4;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_INVALID = 2'd1;
	localparam logic [1:0] STS_RECT    = 2'd2;
	localparam logic [1:0] STS_NOSTR   = 2'd3;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_RD   = 2'd1;
	localparam logic [1:0] MODE_WR   = 2'd2;

	localparam logic [1:0] REG_RED   = 2'd0;
	localparam logic [1:0] REG_GREEN = 2'd1;
	localparam logic [1:0] REG_BLUE  = 2'd2;
	localparam logic [1:0] REG_PITCH = 2'd3;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} mask_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	function automatic logic [15:0] pack_pix(input rgb_t c, input mask_t m);
		pack_pix = ({c.red, 8'b0} & m.red) | ({5'b0, c.green, 3'b0} & m.green) |
			({11'b0, c.blue[7:3]} & m.blue);
	endfunction

	function automatic rgb_t unpack_pix(input logic [15:0] p, input mask_t m);
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		r = p & m.red;
		g = p & m.green;
		b = p & m.blue;
		unpack_pix.red   = r[15:8];
		unpack_pix.green = g[10:3];
		unpack_pix.blue  = {b[4:0], 3'b0};
	endfunction

endpackage

### src/rrb_ram.sv
`timescale 1ns / 1ps
module rrb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 76800
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### src/rgb565_rectangle_blitter_top.sv
`timescale 1ns / 1ps
// fill: one pixel per cycle after the setup state, result posted at acceptance
// copy: setup state, one pixel per cycle on the frame store ports, then a drain state
// stream pixel: through the multiply and address states (write), plus a read state (read)
// begin, invalid and rejected commands: result posted at acceptance; cfg_ready is always high
// arst_n resets control, masks and pitch to their defaults; the frame store is not cleared
module rgb565_rectangle_blitter_top #(
	parameter int FRAME_WIDTH  = 320,
	parameter int FRAME_HEIGHT = 240
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cmd, src_x, src_y, dst_x, dst_y, rect_width, rect_height, host_pitch_bytes,
	// in_red, in_green, in_blue, zero pad
	input  logic [119:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, out_red, out_green, out_blue, host_index, zero pad
	output logic [55:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import rrb_pkg::*;

	localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW  = $clog2(PIX);
	localparam logic [12:0] FW13  = 13'(FRAME_WIDTH);
	localparam logic [12:0] FH13  = 13'(FRAME_HEIGHT);
	localparam logic [24:0] PIX25 = 25'(PIX);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_FILL  = 3'd2;
	localparam logic [2:0] ST_COPY  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_SMUL  = 3'd5;
	localparam logic [2:0] ST_SADR  = 3'd6;
	localparam logic [2:0] ST_SRD   = 3'd7;

	logic [2:0] state_q;
	mask_t mask_q;
	logic [8:0] line_pitch_q;
	logic [8:0] p;

	// input fields
	logic [2:0] in_cmd;
	logic [11:0] in_sx, in_sy, in_dx, in_dy, in_w, in_h;
	logic [15:0] in_pb;
	rgb_t in_rgb;
	logic in_acc;

	// operation registers
	logic op_fill_q, down_q, rev_q;
	logic [11:0] sx_q, sy_q, dx_q, dy_q, w_q, h_q;
	logic [15:0] pix_q;
	logic [23:0] src_row_q, dst_row_q;
	logic [11:0] col_q, rows_left_q;
	logic cp_vld_s1;
	logic [23:0] cp_addr_s1;

	// stream state
	logic [1:0] mode_q;
	logic [11:0] fx_q, fy_q, fw_q, fh_q, hx_q, hy_q, cur_col_q, cur_line_q;
	logic [13:0] hp_q;
	logic [21:0] prodf_q;
	logic [23:0] prodh_q;
	logic rd_ok_q;

	// result register
	logic out_valid_q;
	logic [1:0] out_status_q;
	rgb_t out_rgb_q;
	logic [23:0] out_hidx_q;
	logic out_last_q;

	// ram ports
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0] ram_wdata, ram_rdata;

	logic fit_s, fit_d, empty;
	logic [12:0] k0, srow, drow;
	logic [21:0] mul_s, mul_d;
	logic [23:0] cur_addr, faddr, hidx;
	logic faddr_ok, at_end, s_last, col_wrap;
	logic [11:0] col_first;

	assign in_cmd    = s_axis_tdata[2:0];
	assign in_sx     = s_axis_tdata[14:3];
	assign in_sy     = s_axis_tdata[26:15];
	assign in_dx     = s_axis_tdata[38:27];
	assign in_dy     = s_axis_tdata[50:39];
	assign in_w      = s_axis_tdata[62:51];
	assign in_h      = s_axis_tdata[74:63];
	assign in_pb     = s_axis_tdata[90:75];
	assign in_rgb    = rgb_t'({s_axis_tdata[114:107], s_axis_tdata[106:99],
		s_axis_tdata[98:91]});

	assign p = ({4'b0, line_pitch_q} > FW13) ? FW13[8:0] : line_pitch_q;

	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign fit_s = (({1'b0, in_sx} + {1'b0, in_w}) <= {4'b0, p}) &&
		(({1'b0, in_sy} + {1'b0, in_h}) <= FH13);
	assign fit_d = (({1'b0, in_dx} + {1'b0, in_w}) <= {4'b0, p}) &&
		(({1'b0, in_dy} + {1'b0, in_h}) <= FH13);
	assign empty = (in_w == 12'd0) || (in_h == 12'd0);

	// setup: first line of the sweep
	assign k0    = down_q ? 13'd0 : ({1'b0, h_q} - 13'd1);
	assign srow  = {1'b0, sy_q} + k0;
	assign drow  = {1'b0, dy_q} + k0;
	assign mul_s = {9'b0, srow} * {13'b0, p};
	assign mul_d = {9'b0, drow} * {13'b0, p};
	assign col_first = rev_q ? (w_q - 12'd1) : 12'd0;

	assign at_end = rev_q ? (col_q == 12'd0) : (col_q == (w_q - 12'd1));

	// stream addressing
	assign faddr    = {2'b0, prodf_q} + {12'b0, fx_q} + {12'b0, cur_col_q};
	assign faddr_ok = {1'b0, faddr} < PIX25;
	assign hidx     = prodh_q + {12'b0, hx_q} + {12'b0, cur_col_q};
	assign s_last   = (({1'b0, cur_col_q} + 13'd1) >= {1'b0, fw_q}) &&
		(({1'b0, cur_line_q} + 13'd1) >= {1'b0, fh_q});
	assign col_wrap = ({1'b0, cur_col_q} + 13'd1) >= {1'b0, fw_q};

	assign cur_addr = (state_q == ST_COPY) ? (src_row_q + {12'b0, col_q}) : faddr;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dst_row_q[AW-1:0] + AW'(col_q);
		ram_wdata = pix_q;
		if (cp_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_addr_s1[AW-1:0];
			ram_wdata = ram_rdata;
		end else if (state_q == ST_FILL) begin
			ram_we = 1'b1;
		end else if (state_q == ST_SADR && mode_q == MODE_WR && faddr_ok) begin
			ram_we    = 1'b1;
			ram_waddr = faddr[AW-1:0];
		end
	end

	assign ram_raddr = cur_addr[AW-1:0];

	rrb_ram #(
		.WIDTH(16),
		.DEPTH(PIX)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (1'b1),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= '{red: 16'hF800, green: 16'h07E0, blue: 16'h001F};
			line_pitch_q <= 9'd320;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RED:   mask_q.red   <= cfg_data;
				REG_GREEN: mask_q.green <= cfg_data;
				REG_BLUE:  mask_q.blue  <= cfg_data;
				REG_PITCH: line_pitch_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prodf_q <= {9'b0, {1'b0, fy_q} + {1'b0, cur_line_q}} * {13'b0, p};
		prodh_q <= 24'({14'b0, {1'b0, fy_q} + 13'd0} * 27'd0) +
			24'({14'b0, {1'b0, hy_q} + {1'b0, cur_line_q}} * {13'b0, hp_q});
		cp_addr_s1 <= dst_row_q + {12'b0, col_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			out_status_q <= STS_OK;
			out_rgb_q    <= '0;
			out_hidx_q   <= '0;
			out_last_q   <= 1'b0;
			mode_q       <= MODE_NONE;
			fx_q <= '0; fy_q <= '0; fw_q <= '0; fh_q <= '0;
			hx_q <= '0; hy_q <= '0; hp_q <= '0;
			cur_col_q <= '0; cur_line_q <= '0;
			cp_vld_s1 <= 1'b0;
			op_fill_q <= 1'b0; down_q <= 1'b1; rev_q <= 1'b0;
			sx_q <= '0; sy_q <= '0; dx_q <= '0; dy_q <= '0; w_q <= '0; h_q <= '0;
			pix_q <= '0; src_row_q <= '0; dst_row_q <= '0;
			col_q <= '0; rows_left_q <= '0; rd_ok_q <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			cp_vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sx_q <= in_sx; sy_q <= in_sy; dx_q <= in_dx; dy_q <= in_dy;
						w_q <= in_w; h_q <= in_h;
						pix_q <= pack_pix(in_rgb, mask_q);
						out_rgb_q  <= '0;
						out_hidx_q <= '0;
						out_last_q <= 1'b0;
						out_valid_q <= 1'b1;
						out_status_q <= STS_OK;
						case (in_cmd)
							CMD_FILL: begin
								if (!fit_d) begin
									out_status_q <= STS_RECT;
								end else if (!empty) begin
									op_fill_q <= 1'b1;
									down_q <= 1'b1;
									rev_q <= 1'b0;
									state_q <= ST_SETUP;
								end
							end
							CMD_BEGIN_RD, CMD_BEGIN_WR: begin
								if ((in_cmd == CMD_BEGIN_RD) ? !fit_s : !fit_d) begin
									out_status_q <= STS_RECT;
								end else begin
									fx_q <= (in_cmd == CMD_BEGIN_RD) ? in_sx : in_dx;
									fy_q <= (in_cmd == CMD_BEGIN_RD) ? in_sy : in_dy;
									hx_q <= (in_cmd == CMD_BEGIN_RD) ? in_dx : in_sx;
									hy_q <= (in_cmd == CMD_BEGIN_RD) ? in_dy : in_sy;
									fw_q <= in_w;
									fh_q <= in_h;
									hp_q <= (in_pb != 16'd0 && in_pb != {2'b0, in_w, 2'b0}) ?
										in_pb[15:2] : {2'b0, in_w};
									cur_col_q  <= '0;
									cur_line_q <= '0;
									mode_q <= empty ? MODE_NONE :
										((in_cmd == CMD_BEGIN_RD) ? MODE_RD : MODE_WR);
								end
							end
							CMD_COPY: begin
								if (!fit_s || !fit_d) begin
									out_status_q <= STS_RECT;
								end else if (!empty) begin
									op_fill_q <= 1'b0;
									down_q <= in_dy <= in_sy;
									rev_q <= in_dx > in_sx;
									state_q <= ST_SETUP;
								end
							end
							CMD_STREAM: begin
								if (mode_q == MODE_NONE) begin
									out_status_q <= STS_NOSTR;
								end else begin
									out_valid_q <= 1'b0;
									state_q <= ST_SMUL;
								end
							end
							default: out_status_q <= STS_INVALID;
						endcase
					end
				end
				ST_SETUP: begin
					src_row_q   <= {2'b0, mul_s} + {12'b0, sx_q};
					dst_row_q   <= {2'b0, mul_d} + {12'b0, dx_q};
					col_q       <= col_first;
					rows_left_q <= h_q;
					state_q     <= op_fill_q ? ST_FILL : ST_COPY;
				end
				ST_FILL: begin
					if (at_end) begin
						if (rows_left_q == 12'd1) begin
							state_q <= ST_IDLE;
						end else begin
							rows_left_q <= rows_left_q - 12'd1;
							dst_row_q <= dst_row_q + {15'b0, p};
							col_q <= col_first;
						end
					end else begin
						col_q <= col_q + 12'd1;
					end
				end
				ST_COPY: begin
					cp_vld_s1 <= 1'b1;
					if (at_end) begin
						if (rows_left_q == 12'd1) begin
							state_q <= ST_DRAIN;
						end else begin
							rows_left_q <= rows_left_q - 12'd1;
							src_row_q <= down_q ? (src_row_q + {15'b0, p}) :
								(src_row_q - {15'b0, p});
							dst_row_q <= down_q ? (dst_row_q + {15'b0, p}) :
								(dst_row_q - {15'b0, p});
							col_q <= col_first;
						end
					end else begin
						col_q <= rev_q ? (col_q - 12'd1) : (col_q + 12'd1);
					end
				end
				ST_DRAIN: state_q <= ST_IDLE;
				ST_SMUL: state_q <= ST_SADR;
				ST_SADR: begin
					out_hidx_q   <= hidx;
					out_last_q   <= s_last;
					out_status_q <= STS_OK;
					out_rgb_q    <= '0;
					rd_ok_q      <= faddr_ok;
					if (mode_q == MODE_RD) begin
						state_q <= ST_SRD;
					end else begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
					if (s_last) begin
						mode_q <= MODE_NONE;
						cur_col_q <= '0;
						cur_line_q <= '0;
					end else if (col_wrap) begin
						cur_col_q <= '0;
						cur_line_q <= cur_line_q + 12'd1;
					end else begin
						cur_col_q <= cur_col_q + 12'd1;
					end
				end
				ST_SRD: begin
					out_rgb_q <= rd_ok_q ? unpack_pix(ram_rdata, mask_q) : '0;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'b0, out_hidx_q, out_rgb_q.blue, out_rgb_q.green,
		out_rgb_q.red, out_status_q};

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (state_q == ST_IDLE))
		else $error("input taken while busy");
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3)
		else $error("stream mode corrupt");
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_NONE) |-> (cur_col_q < fw_q && cur_line_q < fh_q))
		else $error("stream cursor outside rectangle");
	a_rd_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRD) |-> !out_valid_q)
		else $error("result slot busy on stream read");
	a_copy_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> ($past(state_q) == ST_COPY))
		else $error("copy write without read");
`endif
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import rrb_pkg::*;

	localparam int FW = 320;
	localparam int FH = 240;
	localparam int NPIX = FW * FH;

	typedef struct {
		logic [2:0]  cmd;
		logic [11:0] sx, sy, dx, dy, w, h;
		logic [15:0] pb;
		rgb_t        c;
	} blit_req_t;

	typedef struct {
		logic [1:0]  status;
		rgb_t        c;
		logic [23:0] idx;
		logic        last;
	} blit_rsp_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [55:0]  m_axis_tdata;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [15:0]  cfg_data;

	rgb565_rectangle_blitter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the block state
	logic [15:0] frame_shadow [0:NPIX-1];
	logic [15:0] copy_buf [0:NPIX-1];
	mask_t       masks;
	logic [8:0]  lpitch;
	logic [1:0]  smode;
	int unsigned ccol, cline, sfx, sfy, sw, sh, shx, shy, shp;

	blit_req_t pending [$];
	blit_rsp_t pixel_results [$];
	blit_req_t cur;
	bit        in_taken;
	bit        calm;
	int        hold_req, hold_seen, hold_left;
	int        errors, n_items, n_results, n_stream, n_cfg;
	int        settle;
	int unsigned gen_pitch;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_RED;
		cfg_data = '0;
	end

	always #2 clk = ~clk;

	initial begin
		#20_000_000;
		$display("rgb565_rectangle_blitter_top regression: fail");
		$finish;
	end

	function automatic int unsigned pitch_eff();
		return (lpitch > FW) ? FW : lpitch;
	endfunction

	function automatic bit fits(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
		return (x + w <= pitch_eff()) && (y + h <= FH);
	endfunction

	function automatic logic [15:0] to565(rgb_t c);
		logic [15:0] r, g, b;
		r = {c.red, 8'b0} & masks.red;
		g = {5'b0, c.green, 3'b0} & masks.green;
		b = {11'b0, c.blue[7:3]} & masks.blue;
		return r | g | b;
	endfunction

	function automatic rgb_t from565(logic [15:0] px);
		rgb_t        o;
		logic [15:0] r, g, b;
		r = px & masks.red;
		g = px & masks.green;
		b = px & masks.blue;
		o.red = r[15:8];
		o.green = g[10:3];
		o.blue = {b[4:0], 3'b0};
		return o;
	endfunction

	task automatic open_stream(logic [1:0] m, int unsigned fx, int unsigned fy,
			int unsigned hx, int unsigned hy, int unsigned w, int unsigned h, int unsigned pb);
		sfx = fx; sfy = fy; sw = w; sh = h; shx = hx; shy = hy;
		shp = (pb != 0 && pb != w * 4) ? ((pb >> 2) & 16'h3FFF) : w;
		ccol = 0;
		cline = 0;
		smode = (w == 0 || h == 0) ? MODE_NONE : m;
	endtask

	task automatic blit_predict(input blit_req_t q, output blit_rsp_t e);
		int unsigned p, i, j, k, addr, hidx;
		logic [15:0] px;
		p = pitch_eff();
		e.status = STS_OK;
		e.c = '0;
		e.idx = '0;
		e.last = 1'b0;
		case (q.cmd)
			CMD_FILL: begin
				if (!fits(q.dx, q.dy, q.w, q.h)) e.status = STS_RECT;
				else begin
					px = to565(q.c);
					for (i = 0; i < q.h; i++)
						for (j = 0; j < q.w; j++)
							frame_shadow[(q.dy + i) * p + q.dx + j] = px;
				end
			end
			CMD_BEGIN_RD: begin
				if (!fits(q.sx, q.sy, q.w, q.h)) e.status = STS_RECT;
				else open_stream(MODE_RD, q.sx, q.sy, q.dx, q.dy, q.w, q.h, q.pb);
			end
			CMD_BEGIN_WR: begin
				if (!fits(q.dx, q.dy, q.w, q.h)) e.status = STS_RECT;
				else open_stream(MODE_WR, q.dx, q.dy, q.sx, q.sy, q.w, q.h, q.pb);
			end
			CMD_COPY: begin
				if (!fits(q.sx, q.sy, q.w, q.h) || !fits(q.dx, q.dy, q.w, q.h))
					e.status = STS_RECT;
				else begin
					// take the source whole first so overlap cannot corrupt it
					k = 0;
					for (i = 0; i < q.h; i++)
						for (j = 0; j < q.w; j++) begin
							copy_buf[k] = frame_shadow[(q.sy + i) * p + q.sx + j];
							k++;
						end
					k = 0;
					for (i = 0; i < q.h; i++)
						for (j = 0; j < q.w; j++) begin
							frame_shadow[(q.dy + i) * p + q.dx + j] = copy_buf[k];
							k++;
						end
				end
			end
			CMD_STREAM: begin
				if (smode == MODE_NONE) e.status = STS_NOSTR;
				else begin
					n_stream++;
					addr = (sfy + cline) * p + sfx + ccol;
					hidx = (shy + cline) * shp + shx + ccol;
					e.idx = hidx[23:0];
					e.last = (ccol + 1 >= sw) && (cline + 1 >= sh);
					if (smode == MODE_RD) begin
						if (addr < NPIX) e.c = from565(frame_shadow[addr]);
					end else if (addr < NPIX) frame_shadow[addr] = to565(q.c);
					if (e.last) begin
						smode = MODE_NONE;
						ccol = 0;
						cline = 0;
					end else begin
						ccol++;
						if (ccol >= sw) begin
							ccol = 0;
							cline = (cline + 1) & 12'hFFF;
						end
					end
				end
			end
			default: e.status = STS_INVALID;
		endcase
	endtask

	task automatic flag_mismatch(string what, longint got, longint exp_v);
		$display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, exp_v);
		errors++;
	endtask

	// input transfer accepted: predict its result
	always @(posedge clk) begin
		blit_rsp_t e;
		in_taken = s_axis_tvalid && s_axis_tready;
		if (in_taken) begin
			blit_predict(cur, e);
			pixel_results.push_back(e);
			n_items++;
		end
	end

	always @(negedge clk) begin
		blit_req_t q;
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (pending.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
				q = pending.pop_front();
				cur <= q;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {5'b0, q.c.blue, q.c.green, q.c.red, q.pb, q.h, q.w,
					q.dy, q.dx, q.sy, q.sx, q.cmd};
			end else s_axis_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = 400;
			m_axis_tready <= 1'b0;
		end else m_axis_tready <= calm || ($urandom_range(99) >= 31);
	end

	always @(posedge clk) begin
		blit_rsp_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pixel_results.size() == 0) begin
				$display("unexpected result transfer at %0t", $time);
				errors++;
			end else begin
				e = pixel_results.pop_front();
				if (m_axis_tdata[1:0] !== e.status) flag_mismatch("status", m_axis_tdata[1:0], e.status);
				if (m_axis_tdata[9:2] !== e.c.red) flag_mismatch("red", m_axis_tdata[9:2], e.c.red);
				if (m_axis_tdata[17:10] !== e.c.green)
					flag_mismatch("green", m_axis_tdata[17:10], e.c.green);
				if (m_axis_tdata[25:18] !== e.c.blue)
					flag_mismatch("blue", m_axis_tdata[25:18], e.c.blue);
				if (m_axis_tdata[49:26] !== e.idx)
					flag_mismatch("host index", m_axis_tdata[49:26], e.idx);
				if (m_axis_tlast !== e.last) flag_mismatch("last", m_axis_tlast, e.last);
			end
		end
	end

	task automatic put(logic [2:0] cmd, int unsigned sx, int unsigned sy, int unsigned dx,
			int unsigned dy, int unsigned w, int unsigned h, int unsigned pb, rgb_t c);
		blit_req_t q;
		q.cmd = cmd; q.sx = 12'(sx); q.sy = 12'(sy); q.dx = 12'(dx); q.dy = 12'(dy);
		q.w = 12'(w); q.h = 12'(h); q.pb = 16'(pb); q.c = c;
		// only a rectangle that can lie in the frame keeps the block busy
		if ((cmd == CMD_FILL || cmd == CMD_COPY) && q.w * q.h <= NPIX &&
				q.w * q.h + 20 > settle)
			settle = q.w * q.h + 20;
		pending.push_back(q);
	endtask

	function automatic rgb_t rnd_rgb();
		return rgb_t'(24'($urandom));
	endfunction

	task automatic drain();
		while (pending.size() > 0 || s_axis_tvalid || pixel_results.size() > 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
		settle = 20;
	endtask

	task automatic reg_write(logic [1:0] idx, logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RED:   masks.red = v;
			REG_GREEN: masks.green = v;
			REG_BLUE:  masks.blue = v;
			default: begin
				lpitch = v[8:0];
				gen_pitch = (v[8:0] > FW) ? FW : v[8:0];
			end
		endcase
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_all(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic [8:0] p);
		reg_write(REG_RED, r);
		reg_write(REG_GREEN, g);
		reg_write(REG_BLUE, b);
		reg_write(REG_PITCH, {7'b0, p});
	endtask

	task automatic small_rect(output int unsigned x, output int unsigned y,
			output int unsigned w, output int unsigned h);
		w = $urandom_range(1, (gen_pitch < 6) ? gen_pitch : 6);
		h = $urandom_range(1, 4);
		x = $urandom_range(0, gen_pitch - w);
		y = $urandom_range(0, FH - h);
	endtask

	task automatic random_items(int n);
		int cnt, sel, k, npx;
		int unsigned x, y, w, h, x2, y2, pb;
		cnt = 0;
		while (cnt < n) begin
			sel = $urandom_range(99);
			small_rect(x, y, w, h);
			if (sel < 55) begin
				case ($urandom_range(2))
					0: pb = 0;
					1: pb = w * 4;
					default: pb = $urandom_range(0, 65535);
				endcase
				put(($urandom_range(1)) ? CMD_BEGIN_RD : CMD_BEGIN_WR, x, y, x, y, w, h, pb,
					rnd_rgb());
				if (sel < 40) begin
					// begin-write uses src as host origin, begin-read uses dst
					pending[$].sx = 12'($urandom_range(0, 4095));
					pending[$].sy = 12'($urandom_range(0, 4095));
					if (pending[$].cmd == CMD_BEGIN_RD) begin
						pending[$].dx = pending[$].sx;
						pending[$].dy = pending[$].sy;
						pending[$].sx = 12'(x);
						pending[$].sy = 12'(y);
					end
				end
				npx = w * h;
				if ($urandom_range(9) == 0) npx = $urandom_range(0, npx + 2);
				for (k = 0; k < npx; k++) begin
					if ($urandom_range(19) == 0) begin
						small_rect(x2, y2, w, h);
						put(CMD_FILL, 0, 0, x2, y2, w, h, 0, rnd_rgb());
						cnt++;
					end
					put(CMD_STREAM, $urandom_range(0, 4095), $urandom_range(0, 4095), 0, 0,
						$urandom_range(0, 4095), 0, $urandom_range(0, 65535), rnd_rgb());
				end
				cnt += npx + 1;
			end else if (sel < 70) begin
				put(CMD_FILL, 0, 0, x, y, w, h, 0, rnd_rgb());
				cnt++;
			end else if (sel < 82) begin
				x2 = x + $urandom_range(0, 4);
				x2 = (x2 < 2) ? 0 : x2 - 2;
				if (x2 + w > gen_pitch) x2 = gen_pitch - w;
				y2 = y + $urandom_range(0, 4);
				y2 = (y2 < 2) ? 0 : y2 - 2;
				if (y2 + h > FH) y2 = FH - h;
				put(CMD_COPY, x, y, x2, y2, w, h, 0, rnd_rgb());
				cnt++;
			end else if (sel < 83) begin
				w = $urandom_range(1, gen_pitch);
				h = $urandom_range(1, 60);
				put(($urandom_range(1)) ? CMD_FILL : CMD_COPY, 0, 0, gen_pitch - w, FH - h,
					w, h, 0, rnd_rgb());
				cnt++;
			end else begin
				put(3'($urandom_range(0, 7)), $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 65535), rnd_rgb());
				cnt++;
			end
		end
	endtask

	initial begin
		int ph, k;
		rgb_t white, black;
		white = '1;
		black = '0;
		masks = '{red: 16'hF800, green: 16'h07E0, blue: 16'h001F};
		lpitch = 9'd320;
		gen_pitch = FW;
		smode = MODE_NONE;
		ccol = 0; cline = 0; sfx = 0; sfy = 0; sw = 0; sh = 0; shx = 0; shy = 0; shp = 0;
		errors = 0; n_items = 0; n_results = 0; n_stream = 0; n_cfg = 0;
		hold_req = 0; hold_seen = 0; hold_left = 0;
		calm = 1'b0;
		settle = 20;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// whole frame written first so no read ever sees an unwritten pixel
		put(CMD_FILL, 0, 0, 0, 0, FW, FH, 0, rnd_rgb());
		put(CMD_FILL, 0, 0, 0, 0, 4, 2, 0, white);
		put(CMD_FILL, 0, 0, 316, 238, 4, 2, 0, black);
		put(CMD_FILL, 0, 0, 317, 0, 4, 1, 0, white);
		put(CMD_FILL, 0, 0, 0, 4095, 1, 1, 0, white);
		put(CMD_FILL, 0, 0, 320, 0, 0, 5, 0, white);
		put(CMD_COPY, 0, 0, 2, 1, 6, 4, 0, black);
		put(CMD_COPY, 2, 1, 0, 0, 6, 4, 0, black);
		put(CMD_COPY, 0, 0, 315, 0, 6, 4, 0, black);
		put(CMD_STREAM, 0, 0, 0, 0, 0, 0, 0, white);
		put(3'd5, 0, 0, 0, 0, 1, 1, 0, black);
		put(3'd6, 0, 0, 0, 0, 1, 1, 0, black);
		put(3'd7, 4095, 4095, 4095, 4095, 4095, 4095, 65535, white);
		// host index runs past 24 bits
		put(CMD_BEGIN_RD, 0, 0, 4095, 4095, 3, 2, 65535, black);
		for (k = 0; k < 6; k++) put(CMD_STREAM, 0, 0, 0, 0, 0, 0, 0, black);
		put(CMD_BEGIN_WR, 1, 1, 10, 10, 2, 2, 8, black);
		for (k = 0; k < 4; k++) put(CMD_STREAM, 0, 0, 0, 0, 0, 0, 0, k[0] ? white : black);
		put(CMD_BEGIN_RD, 10, 10, 0, 0, 2, 2, 0, black);
		for (k = 0; k < 4; k++) put(CMD_STREAM, 0, 0, 0, 0, 0, 0, 0, black);
		put(CMD_BEGIN_RD, 0, 0, 0, 0, 0, 3, 0, black);
		put(CMD_STREAM, 0, 0, 0, 0, 0, 0, 0, black);
		put(CMD_BEGIN_WR, 0, 0, 0, 0, 2, 1, 0, black);
		put(CMD_STREAM, 0, 0, 0, 0, 0, 0, 0, white);
		put(CMD_BEGIN_RD, 0, 0, 0, 0, 2, 1, 0, black);
		put(CMD_FILL, 0, 0, 100, 100, 3, 3, 0, white);
		put(CMD_STREAM, 0, 0, 0, 0, 0, 0, 0, black);
		put(CMD_STREAM, 0, 0, 0, 0, 0, 0, 0, black);
		put(CMD_BEGIN_RD, 0, 0, 7, 3, 4, 3, 0, black);
		for (k = 0; k < 3; k++) put(CMD_STREAM, 0, 0, 0, 0, 0, 0, 0, black);
		drain();
		// pitch changed while a stream is open
		reg_write(REG_PITCH, 16'd200);
		for (k = 0; k < 9; k++) put(CMD_STREAM, 0, 0, 0, 0, 0, 0, 0, black);
		drain();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_all(16'hF800, 16'h07E0, 16'h001F, 9'd320);
				1: set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd320);
				2: set_all(16'h0000, 16'h0000, 16'h0000, 9'd1);
				3: set_all(16'hF800, 16'h07E0, 16'h001F, 9'd16);
				default: set_all(16'($urandom), 16'($urandom), 16'($urandom),
					9'($urandom_range(1, 320)));
			endcase
			calm = (ph == 4);
			random_items(130);
			if (ph == 3) hold_req++;
			drain();
		end
		calm = 1'b0;
		repeat (100) @(posedge clk);

		$display("items %0d, results %0d, stream pixels %0d, register writes %0d, mismatches %0d",
			n_items, n_results, n_stream, n_cfg, errors);
		$display("covered fills, overlapping copies, read and write streams, rejected rectangles");
		if (errors == 0 && pixel_results.size() == 0)
			$display("rgb565_rectangle_blitter_top regression: pass");
		else begin
			if (pixel_results.size() != 0)
				$display("%0d results never arrived", pixel_results.size());
			$display("rgb565_rectangle_blitter_top regression: fail");
		end
		$finish;
	end

endmodule

### sim.f
src/rrb_pkg.sv
src/rrb_ram.sv
src/rgb565_rectangle_blitter_top.sv
tb/sv/tb.sv
